[hdl/iols_pkg.sv]
// Package: payload types, command and status codes for the indexed ordered list store.
package iols_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_RETRIEVE = 3'd2,
    CMD_REPLACE  = 3'd3,
    CMD_EXISTS   = 3'd4,
    CMD_SWAP     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  position;
    logic [3:0]  second_position;
    logic [31:0] word;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] read_word;
    logic        found;
    logic [4:0]  entry_count;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctl_t;

endpackage

[hdl/iols_store.sv]
// Entry memory: one write port, one read port with registered read data.
module iols_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/iols_seq.sv]
// Sequencer: decodes a command, walks the memory one entry a cycle, forms the result.
module iols_seq #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  iols_pkg::req_t              req_i,
  input  logic                        res_taken_i,
  output iols_pkg::ctl_t              ctl_o,
  output iols_pkg::res_t              res_o,
  output logic                        mem_we_o,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr_o,
  output logic [DATA_WIDTH-1:0]       mem_wdata_o,
  output logic                        mem_re_o,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]       mem_rdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 5) ? CW : 5;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_FETCH    = 10'b0000000010,
    S_MOVE     = 10'b0000000100,
    S_WR_WORD  = 10'b0000001000,
    S_RETR     = 10'b0000010000,
    S_SCAN     = 10'b0000100000,
    S_SWAP_RD2 = 10'b0001000000,
    S_SWAP_WR1 = 10'b0010000000,
    S_SWAP_WR2 = 10'b0100000000,
    S_RESULT   = 10'b1000000000
  } state_e;

  state_e                    state_q, state_d;
  logic [2:0]                cmd_q, cmd_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [AW-1:0]             pos2_q, pos2_d;
  logic [AW-1:0]             dst_q, dst_d;
  logic [CW-1:0]             src_q, src_d;
  logic [CW-1:0]             count_q, count_d;
  logic [DATA_WIDTH-1:0]     word_q, word_d;
  logic [DATA_WIDTH-1:0]     rword_q, rword_d;
  iols_pkg::status_e         status_q, status_d;
  logic                      found_q, found_d;

  logic [PW-1:0]             pos_x, pos2_x, cnt_x;
  logic [CW-1:0]             src_nxt;
  logic                      walk_up, match, pos_ok, more;

  // shared walk adder and word comparator
  assign walk_up = (cmd_q != iols_pkg::CMD_INSERT);
  assign src_nxt = walk_up ? src_q + CW'(1) : src_q - CW'(1);
  assign match   = (mem_rdata_i == word_q);
  assign pos_x   = PW'(req_i.position);
  assign pos2_x  = PW'(req_i.second_position);
  assign cnt_x   = PW'(count_q);
  assign pos_ok  = pos_x < cnt_x;
  assign more    = (cmd_q == iols_pkg::CMD_INSERT) ? (src_q > CW'(pos_q)) : (src_q < count_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    pos2_d      = pos2_q;
    dst_d       = dst_q;
    src_d       = src_q;
    count_d     = count_q;
    word_d      = word_q;
    rword_d     = rword_q;
    status_d    = status_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = dst_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = src_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = req_i.command;
          pos_d    = AW'(req_i.position);
          pos2_d   = AW'(req_i.second_position);
          word_d   = DATA_WIDTH'(req_i.word);
          status_d = iols_pkg::ST_DONE;
          found_d  = 1'b0;
          rword_d  = '0;
          state_d  = S_RESULT;
          unique case (req_i.command)
            iols_pkg::CMD_INSERT: begin
              if (pos_x > cnt_x) begin
                status_d = iols_pkg::ST_RANGE;
              end else if (count_q == CW'(CAPACITY)) begin
                status_d = iols_pkg::ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
                if (pos_x == cnt_x) begin
                  state_d = S_WR_WORD;
                end else begin
                  dst_d   = count_q[AW-1:0];
                  src_d   = count_q - CW'(1);
                  state_d = S_FETCH;
                end
              end
            end
            iols_pkg::CMD_REMOVE: begin
              if (!pos_ok) begin
                status_d = iols_pkg::ST_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                dst_d   = AW'(req_i.position);
                src_d   = CW'(req_i.position) + CW'(1);
                if ((pos_x + PW'(1)) < cnt_x) begin
                  state_d = S_FETCH;
                end
              end
            end
            iols_pkg::CMD_RETRIEVE: begin
              if (!pos_ok) begin
                status_d = iols_pkg::ST_RANGE;
              end else begin
                src_d   = CW'(req_i.position);
                state_d = S_FETCH;
              end
            end
            iols_pkg::CMD_REPLACE: begin
              if (!pos_ok) begin
                status_d = iols_pkg::ST_RANGE;
              end else begin
                state_d = S_WR_WORD;
              end
            end
            iols_pkg::CMD_EXISTS: begin
              if (count_q != '0) begin
                src_d   = '0;
                state_d = S_FETCH;
              end
            end
            iols_pkg::CMD_SWAP: begin
              if (!pos_ok || !(pos2_x < cnt_x)) begin
                status_d = iols_pkg::ST_RANGE;
              end else begin
                src_d   = CW'(req_i.position);
                state_d = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        mem_re_o = 1'b1;
        unique case (cmd_q) inside
          iols_pkg::CMD_INSERT,
          iols_pkg::CMD_REMOVE:   state_d = S_MOVE;
          iols_pkg::CMD_RETRIEVE: state_d = S_RETR;
          iols_pkg::CMD_EXISTS:   state_d = S_SCAN;
          iols_pkg::CMD_SWAP:     state_d = S_SWAP_RD2;
          default:                state_d = S_RESULT;
        endcase
      end
      S_MOVE: begin
        mem_we_o = 1'b1;
        dst_d    = src_q[AW-1:0];
        src_d    = src_nxt;
        if (more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = src_nxt[AW-1:0];
        end else if (cmd_q == iols_pkg::CMD_INSERT) begin
          state_d = S_WR_WORD;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_WR_WORD: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = word_q;
        state_d     = S_RESULT;
      end
      S_RETR: begin
        rword_d = mem_rdata_i;
        found_d = match;
        state_d = S_RESULT;
      end
      S_SCAN: begin
        if (match) begin
          found_d = 1'b1;
          state_d = S_RESULT;
        end else if (src_nxt < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = src_nxt[AW-1:0];
          src_d       = src_nxt;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SWAP_RD2: begin
        // first entry parked in the word register
        word_d      = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = pos2_q;
        state_d     = S_SWAP_WR1;
      end
      S_SWAP_WR1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        state_d     = S_SWAP_WR2;
      end
      S_SWAP_WR2: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos2_q;
        mem_wdata_o = word_q;
        state_d     = S_RESULT;
      end
      S_RESULT: begin
        if (res_taken_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pos_q    <= pos_d;
    pos2_q   <= pos2_d;
    dst_q    <= dst_d;
    src_q    <= src_d;
    word_q   <= word_d;
    rword_q  <= rword_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign ctl_o.idle      = (state_q == S_IDLE);
  assign ctl_o.res_valid = (state_q == S_RESULT);

  assign res_o.status      = status_q;
  assign res_o.read_word   = 32'(rword_q);
  assign res_o.found       = found_q;
  assign res_o.entry_count = 5'(count_q);

endmodule

[hdl/indexed_ordered_list_store.sv]
// Top level: indexed ordered list store with request and result channels.
//
// Requests arrive on in_valid_i/in_ready_o/in_req_i, one transfer per command;
// results leave on out_valid_o/out_ready_i/out_res_o, one transfer per command.
// The block works on one command at a time and raises in_ready_o only when idle.
// Insert shifts the entries from its position up and then writes the word, or
// writes the word at once when it appends; remove shifts the entries above its
// position down, unless it removes the last entry; exists reads from the first
// entry until a match or the end of the list, and reads nothing on an empty
// list; a rejected or unused command goes straight to the result.
// The walk is set by the one read port of the entry memory: one entry a cycle.
// The result sits in an output register; the next request can be taken while it
// waits, but that request's result is held back until the register is free.
// A stalled receiver therefore stalls the block after at most one more command.
// Reset clears the count and the handshake state; entry contents are not cleared
// and only entries below the count are ever read.
module indexed_ordered_list_store #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  iols_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iols_pkg::res_t out_res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  iols_pkg::ctl_t        ctl;
  iols_pkg::res_t        res;
  iols_pkg::res_t        out_res_q;
  logic                  out_valid_q;
  logic                  res_load;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  iols_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_i       (in_req_i),
    .res_taken_i (res_load),
    .ctl_o       (ctl),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  iols_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_load = ctl.res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= res;
    end
  end

  assign in_ready_o  = ctl.idle;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("block still ready after a request transfer");

  a_ctl_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.idle, ctl.res_valid}))
    else $error("sequencer idle and holding a result at once");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.status == iols_pkg::ST_FULL)
      |-> (out_res_o.entry_count == 5'(CAPACITY)))
    else $error("full status with a count below capacity");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.status != iols_pkg::ST_DONE)
      |-> (out_res_o.read_word == '0 && !out_res_o.found))
    else $error("rejected command reports data");

endmodule
